[src/gbn_pkg.sv]
`default_nettype none
package gbn_pkg;

	localparam int unsigned WINDOW_DEF    = 8;
	localparam int unsigned BACKLOG_DEF   = 64;
	localparam int unsigned SEQ_BITS_DEF  = 16;

	localparam int unsigned PAY_W  = 160;
	localparam int unsigned BSUM_W = 13;
	localparam int unsigned IN_W   = 264;
	localparam int unsigned OUT_W  = 216;
	localparam int unsigned CHK_W  = 36;
	localparam int unsigned SEQO_W = 16;

	localparam logic [15:0] TIMEOUT_RST = 16'd20;
	localparam logic [3:0]  WLIMIT_RST  = 4'd8;

	localparam logic CFG_TIMEOUT = 1'b0;
	localparam logic CFG_WLIMIT  = 1'b1;

	localparam logic [1:0] MODE_MSG  = 2'd0;
	localparam logic [1:0] MODE_ACK  = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	localparam logic [1:0] KIND_NEW  = 2'd0;
	localparam logic [1:0] KIND_RETX = 2'd1;
	localparam logic [1:0] KIND_DROP = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOOP,
		ST_DEMIT,
		ST_FINAL,
		ST_RRD,
		ST_REMIT
	} gbn_state_t;

	typedef struct packed {
		logic [1:0]               mode;
		logic                     ack_ok;
		logic [31:0]              ack_num;
		logic signed [BSUM_W-1:0] bsum;
		logic [PAY_W-1:0]         payload;
	} gbn_item_t;

	typedef struct packed {
		logic [3:0]  outstanding;
		logic [10:0] bl_count;
	} gbn_stat_t;

endpackage
`default_nettype wire

[src/gbn_front.sv]
`default_nettype none
module gbn_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [gbn_pkg::IN_W-1:0]  s_tdata,
	input  wire logic [1:0]                s_tuser,
	output logic                           item_valid,
	output gbn_pkg::gbn_item_t             item,
	input  wire logic                      item_pop
);
	import gbn_pkg::*;

	gbn_item_t               ent_q [2];
	logic                    wp_q, rp_q;
	logic [1:0]              cnt_q;
	gbn_item_t               cls;
	logic signed [BSUM_W-1:0] bs;
	logic signed [36:0]      calc, carried;
	logic                    push;

	always_comb begin
		bs = '0;
		for (int i = 0; i < 20; i++) begin
			bs = bs + BSUM_W'($signed(s_tdata[i*8 +: 8]));
		end
		calc = $signed({5'b0, s_tdata[191:160]}) + $signed({5'b0, s_tdata[223:192]})
			+ 37'(bs);
		carried = 37'($signed(s_tdata[259:224]));
		cls.mode    = s_tuser;
		cls.ack_ok  = (calc == carried);
		cls.ack_num = s_tdata[223:192];
		cls.bsum    = bs;
		cls.payload = s_tdata[PAY_W-1:0];
	end

	assign s_tready   = (cnt_q != 2'd2);
	assign push       = s_tvalid && s_tready;
	assign item_valid = (cnt_q != 2'd0);
	assign item       = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (item_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(item_pop);
		end
	end
endmodule
`default_nettype wire

[src/gbn_back.sv]
`default_nettype none
module gbn_back #(
	parameter int unsigned WINDOW        = gbn_pkg::WINDOW_DEF,
	parameter int unsigned BACKLOG_DEPTH = gbn_pkg::BACKLOG_DEF,
	parameter int unsigned SEQ_BITS      = gbn_pkg::SEQ_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [15:0]                timeout_ticks,
	input  wire logic [3:0]                 window_limit,
	input  wire logic                       item_valid,
	input  wire gbn_pkg::gbn_item_t         item,
	output logic                            item_pop,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [gbn_pkg::OUT_W-1:0]       m_tdata,
	output logic [1:0]                      m_tuser,
	output logic                            m_tlast,
	output gbn_pkg::gbn_stat_t              stat
);
	import gbn_pkg::*;

	localparam int unsigned WW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned BW   = (BACKLOG_DEPTH > 1) ? $clog2(BACKLOG_DEPTH) : 1;
	localparam int unsigned CW   = $clog2(BACKLOG_DEPTH + 1);
	localparam int unsigned WCAP = (WINDOW < 8) ? WINDOW : 8;
	localparam int unsigned EW   = BSUM_W + PAY_W;

	typedef logic [EW-1:0] entry_t;

	gbn_state_t         state_q, state_d;
	logic [SEQ_BITS-1:0] base_q, next_q;
	logic [WW-1:0]      bslot_q;
	logic [BW-1:0]      head_q;
	logic [CW-1:0]      cnt_q;
	logic               trun_q;
	logic [15:0]        tleft_q;
	logic [3:0]         ridx_q, rk_q;
	gbn_item_t          cur_q;

	entry_t             bl_mem [BACKLOG_DEPTH];
	entry_t             win_mem [WINDOW];
	entry_t             bl_rdata_q, win_rdata_q;

	logic               ovalid_q, olast_q;
	logic [1:0]         okind_q;
	logic [SEQO_W-1:0]  oseq_q;
	logic [CHK_W-1:0]   ocheck_q;
	logic [PAY_W-1:0]   opay_q;

	logic [3:0]          wl, eff;
	logic [SEQ_BITS-1:0] o, o1, effs, ack_a, off, a1;
	logic                room, room1, out_free, drain_go, ack_hit, tick_out;
	logic                f_send, f_drop, drain_last, r_last;
	logic [CW-1:0]       c1;
	logic [BW:0]         tail_sum;
	logic [BW-1:0]       tail, head_inc;
	logic [WW-1:0]       slot_new, slot_rd, slot_ack;
	logic                bl_re, bl_we, win_re, win_we, emit, e_zero, e_last, do_send;
	logic [1:0]          e_kind;
	logic [SEQ_BITS-1:0] e_seq;
	entry_t              e_ent;
	logic [31:0]         e_seq32;
	logic [CHK_W-1:0]    e_chk;

	function automatic logic [WW-1:0] wmod(input logic [WW-1:0] a, input logic [WW:0] b);
		logic [WW:0] s;
		s = {1'b0, a} + b;
		if (s >= (WW+1)'(WINDOW)) s = s - (WW+1)'(WINDOW);
		return s[WW-1:0];
	endfunction

	always_comb begin
		wl   = (window_limit == 4'd0) ? 4'd1 : window_limit;
		eff  = (wl > 4'(WCAP)) ? 4'(WCAP) : wl;
		effs = SEQ_BITS'(eff);
		o    = next_q - base_q;
		o1   = o + SEQ_BITS'(1);
		room = (o < effs);
		room1 = (o1 < effs);
		c1   = cnt_q - CW'(1);
		drain_go = (cnt_q != '0) && room;
		drain_last = !((c1 != '0) && room1) && !((cur_q.mode == MODE_MSG) && (c1 == '0) && room1);
		ack_a = cur_q.ack_num[SEQ_BITS-1:0];
		off   = ack_a - base_q;
		a1    = ack_a + SEQ_BITS'(1);
		ack_hit  = cur_q.ack_ok && (off < o);
		tick_out = trun_q && (tleft_q <= 16'd1);
		f_send = (cnt_q == '0) && room;
		f_drop = !f_send && (cnt_q >= CW'(BACKLOG_DEPTH));
		r_last = ((ridx_q + 4'd1) == rk_q);
		out_free = !ovalid_q || m_tready;
		tail_sum = {1'b0, head_q} + (BW+1)'(cnt_q);
		if (tail_sum >= (BW+1)'(BACKLOG_DEPTH)) tail_sum = tail_sum - (BW+1)'(BACKLOG_DEPTH);
		tail = tail_sum[BW-1:0];
		head_inc = (head_q == BW'(BACKLOG_DEPTH - 1)) ? '0 : head_q + BW'(1);
		slot_new = wmod(bslot_q, (WW+1)'(o));
		slot_rd  = wmod(bslot_q, (WW+1)'(ridx_q));
		slot_ack = wmod(bslot_q, (WW+1)'(off) + (WW+1)'(1));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (item_valid) state_d = ST_EXEC;
			ST_EXEC: begin
				case (cur_q.mode)
					MODE_MSG:  state_d = ST_LOOP;
					MODE_ACK:  state_d = ack_hit ? ST_LOOP : ST_IDLE;
					MODE_TICK: state_d = (tick_out && (o != '0)) ? ST_RRD : ST_IDLE;
					default:   state_d = ST_IDLE;
				endcase
			end
			ST_LOOP: begin
				if (drain_go) state_d = ST_DEMIT;
				else if (cur_q.mode == MODE_MSG) state_d = ST_FINAL;
				else state_d = ST_IDLE;
			end
			ST_DEMIT: if (out_free) state_d = ST_LOOP;
			ST_FINAL: if (out_free || !(f_send || f_drop)) state_d = ST_IDLE;
			ST_RRD:   state_d = ST_REMIT;
			ST_REMIT: if (out_free) state_d = r_last ? ST_IDLE : ST_RRD;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_pop = 1'b0;
		bl_re    = 1'b0;
		bl_we    = 1'b0;
		win_re   = 1'b0;
		win_we   = 1'b0;
		emit     = 1'b0;
		do_send  = 1'b0;
		e_zero   = 1'b0;
		e_last   = 1'b0;
		e_kind   = KIND_NEW;
		e_seq    = next_q;
		e_ent    = {cur_q.bsum, cur_q.payload};
		case (state_q)
			ST_IDLE: item_pop = item_valid;
			ST_LOOP: bl_re = drain_go;
			ST_DEMIT: begin
				e_ent = bl_rdata_q;
				if (out_free) begin
					emit    = 1'b1;
					win_we  = 1'b1;
					do_send = 1'b1;
					e_last  = drain_last;
				end
			end
			ST_FINAL: begin
				if (f_send) begin
					if (out_free) begin
						emit    = 1'b1;
						win_we  = 1'b1;
						do_send = 1'b1;
						e_last  = 1'b1;
					end
				end else if (f_drop) begin
					e_kind = KIND_DROP;
					e_zero = 1'b1;
					if (out_free) begin
						emit   = 1'b1;
						e_last = 1'b1;
					end
				end else begin
					bl_we = 1'b1;
				end
			end
			ST_RRD: win_re = 1'b1;
			ST_REMIT: begin
				e_kind = KIND_RETX;
				e_seq  = base_q + SEQ_BITS'(ridx_q);
				e_ent  = win_rdata_q;
				if (out_free) begin
					emit   = 1'b1;
					e_last = r_last;
				end
			end
			default: ;
		endcase
		e_seq32 = 32'(e_seq);
		e_chk = $signed({{(CHK_W-1-SEQ_BITS){1'b0}}, e_seq, 1'b0})
			+ CHK_W'($signed(e_ent[EW-1 -: BSUM_W]));
	end

	always_ff @(posedge clk) begin
		if (bl_we) bl_mem[tail] <= {cur_q.bsum, cur_q.payload};
		if (bl_re) bl_rdata_q <= bl_mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (win_we) win_mem[slot_new] <= e_ent;
		if (win_re) win_rdata_q <= win_mem[slot_rd];
	end

	always_ff @(posedge clk) begin
		if (item_pop) cur_q <= item;
		if (emit) begin
			okind_q  <= e_kind;
			olast_q  <= e_last;
			oseq_q   <= e_zero ? '0 : e_seq32[SEQO_W-1:0];
			ocheck_q <= e_zero ? '0 : e_chk;
			opay_q   <= e_ent[PAY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			base_q   <= '0;
			next_q   <= '0;
			bslot_q  <= '0;
			head_q   <= '0;
			cnt_q    <= '0;
			trun_q   <= 1'b0;
			tleft_q  <= '0;
			ridx_q   <= '0;
			rk_q     <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) ovalid_q <= 1'b1;
			else if (m_tready) ovalid_q <= 1'b0;
			if (state_q == ST_EXEC && cur_q.mode == MODE_ACK && ack_hit) begin
				base_q  <= a1;
				bslot_q <= slot_ack;
				trun_q  <= (a1 != next_q);
				tleft_q <= (a1 != next_q) ? timeout_ticks : 16'd0;
			end
			if (state_q == ST_EXEC && cur_q.mode == MODE_TICK && trun_q) begin
				if (tick_out) begin
					tleft_q <= timeout_ticks;
					rk_q    <= 4'(o);
					ridx_q  <= '0;
				end else begin
					tleft_q <= tleft_q - 16'd1;
				end
			end
			if (do_send) begin
				next_q <= next_q + SEQ_BITS'(1);
				if (o == '0) begin
					trun_q  <= 1'b1;
					tleft_q <= timeout_ticks;
				end
			end
			if (state_q == ST_DEMIT && out_free) begin
				head_q <= head_inc;
				cnt_q  <= c1;
			end
			if (bl_we) cnt_q <= cnt_q + CW'(1);
			if (state_q == ST_REMIT && out_free) ridx_q <= ridx_q + 4'd1;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tuser  = okind_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {4'b0, opay_q, ocheck_q, oseq_q};
	assign stat.outstanding = 4'(o);
	assign stat.bl_count    = 11'(cnt_q);
endmodule
`default_nettype wire

[src/go_back_n_sender.sv]
// Go-Back-N sender.
// Requests enter on s_axis-style group s_tvalid/s_tready/s_tdata/s_tuser;
// s_tuser is the mode (message, ack, timer tick). Packets and drop notices
// leave on m_tvalid/m_tready/m_tdata/m_tuser/m_tlast; m_tuser is the kind,
// m_tlast marks the final result of a request. Registers are written on
// cfg_we with cfg_index 0 = timeout ticks, 1 = window limit.
// A request is classified (byte sum, ack check) on acceptance and queued
// in a two-entry queue. The back end takes it through its idle and exec
// states; each packet drained from the backlog or resent on timeout is
// fetched by a registered read of the backlog or window memory. A plain
// message then passes the loop and final states, and when the back end is
// idle its result goes from the final state into the output register.
// Reset clears sequence state, timer and queues and loads timeout 20,
// window limit 8. When the receiver stalls, the result waits in the
// output register, the back end holds, and the front queue takes up to
// two more requests before s_tready drops.
`default_nettype none
module go_back_n_sender #(
	parameter int unsigned WINDOW        = gbn_pkg::WINDOW_DEF,
	parameter int unsigned BACKLOG_DEPTH = gbn_pkg::BACKLOG_DEF,
	parameter int unsigned SEQ_BITS      = gbn_pkg::SEQ_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// payload_low, payload_mid, payload_high, ack_seq_field, ack_number, ack_check
	input  wire logic [gbn_pkg::IN_W-1:0]  s_tdata,
	// mode
	input  wire logic [1:0]                s_tuser,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	// seq, check, out_payload_low, out_payload_mid, out_payload_high
	output logic [gbn_pkg::OUT_W-1:0]      m_tdata,
	// kind
	output logic [1:0]                     m_tuser,
	output logic                           m_tlast,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [15:0]               cfg_data
);
	import gbn_pkg::*;

	logic [15:0] timeout_q;
	logic [3:0]  wlimit_q;
	logic        item_valid, item_pop;
	gbn_item_t   item;
	gbn_stat_t   stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			wlimit_q  <= WLIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TIMEOUT: timeout_q <= cfg_data;
				CFG_WLIMIT:  wlimit_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	gbn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	gbn_back #(
		.WINDOW        (WINDOW),
		.BACKLOG_DEPTH (BACKLOG_DEPTH),
		.SEQ_BITS      (SEQ_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.timeout_ticks (timeout_q),
		.window_limit  (wlimit_q),
		.item_valid    (item_valid),
		.item          (item),
		.item_pop      (item_pop),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.stat          (stat)
	);

	a_outstanding: assert property (@(posedge clk) disable iff (!arst_n)
		stat.outstanding <= 4'd8) else $error("too many packets in flight");
	a_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		32'(stat.bl_count) <= BACKLOG_DEPTH) else $error("backlog overflow");
	a_drop_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_DROP |-> m_tlast) else $error("drop not last");
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_DROP |-> m_tdata[51:0] == 52'd0)
		else $error("drop carries seq or check");
endmodule
`default_nettype wire
